// ===== rtl/core/wstd_pkg.sv =====
package wstd_pkg;

  localparam int REQ_W    = 2;
  localparam int SRV_W    = 4;
  localparam int WEIGHT_W = 20;
  localparam int DUR_W    = 20;
  localparam int ERR_W    = 2;

  localparam logic [REQ_W-1:0] REQ_LOAD   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_SUBMIT = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd2;

  localparam logic [ERR_W-1:0] ERR_OK        = 2'd0;
  localparam logic [ERR_W-1:0] ERR_NO_SERVER = 2'd1;
  localparam logic [ERR_W-1:0] ERR_FULL      = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_LAST,
    ST_COMMIT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic do_load;
    logic do_clear;
    logic do_submit;
    logic scan_step;
    logic commit;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic any_enabled;
    logic count_full;
    logic scan_last;
    logic out_free;
  } sts_t;

endpackage

// ===== rtl/core/wstd_ram.sv =====
module wstd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

// ===== rtl/core/wstd_ctrl.sv =====
module wstd_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic [wstd_pkg::REQ_W-1:0] in_req_type,
  output logic               in_ready,
  input  wstd_pkg::sts_t     sts,
  output wstd_pkg::cmd_t     cmd
);

  wstd_pkg::state_t state_r, state_nxt;
  logic             accept;

  assign accept = in_valid && (state_r == wstd_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= wstd_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      wstd_pkg::ST_IDLE: begin
        if (accept && in_req_type == wstd_pkg::REQ_SUBMIT) begin
          // Refused submits skip the scan and go straight to commit.
          if (!sts.any_enabled || sts.count_full) begin
            state_nxt = wstd_pkg::ST_COMMIT;
          end else begin
            state_nxt = wstd_pkg::ST_SCAN;
          end
        end
      end
      wstd_pkg::ST_SCAN: begin
        if (sts.scan_last) begin
          state_nxt = wstd_pkg::ST_LAST;
        end
      end
      wstd_pkg::ST_LAST: begin
        state_nxt = wstd_pkg::ST_COMMIT;
      end
      wstd_pkg::ST_COMMIT: begin
        if (sts.out_free) begin
          state_nxt = wstd_pkg::ST_IDLE;
        end
      end
      default: state_nxt = wstd_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      wstd_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (accept) begin
          unique case (in_req_type)
            wstd_pkg::REQ_LOAD:   cmd.do_load   = 1'b1;
            wstd_pkg::REQ_SUBMIT: cmd.do_submit = 1'b1;
            wstd_pkg::REQ_CLEAR:  cmd.do_clear  = 1'b1;
            default: ;
          endcase
        end
      end
      wstd_pkg::ST_SCAN:   cmd.scan_step = 1'b1;
      wstd_pkg::ST_LAST:   ;
      wstd_pkg::ST_COMMIT: cmd.commit = sts.out_free;
      default: ;
    endcase
  end

endmodule

// ===== rtl/core/wstd_dp.sv =====
module wstd_dp #(
  parameter int NUM_SERVERS     = 16,
  parameter int TASK_COUNT_BITS = 24,
  parameter int TIME_BITS       = 48
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  wstd_pkg::cmd_t                cmd,
  output wstd_pkg::sts_t                sts,
  input  logic [wstd_pkg::SRV_W-1:0]    in_server_index,
  input  logic [wstd_pkg::WEIGHT_W-1:0] in_server_weight,
  input  logic [wstd_pkg::DUR_W-1:0]    in_task_duration,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic [wstd_pkg::SRV_W-1:0]    out_assigned_server,
  output logic [TIME_BITS-1:0]          out_start_time,
  output logic [TASK_COUNT_BITS-1:0]    out_task_number,
  output logic [wstd_pkg::ERR_W-1:0]    out_error_code
);

  localparam int IDX_W = (NUM_SERVERS > 1) ? $clog2(NUM_SERVERS) : 1;
  localparam int ENT_W = wstd_pkg::WEIGHT_W + TIME_BITS;

  logic [NUM_SERVERS-1:0]         en_r;
  logic [TIME_BITS-1:0]           clock_r;
  logic [TASK_COUNT_BITS-1:0]     count_r;
  logic [TIME_BITS-1:0]           clk0_r;
  logic [wstd_pkg::DUR_W-1:0]     dur_r;
  logic [wstd_pkg::ERR_W-1:0]     err_r;

  logic [IDX_W-1:0]               scan_idx_r;
  logic                           cmp_v_r;
  logic [IDX_W-1:0]               cmp_idx_r;

  // Best free server and best server among those finishing earliest.
  logic                           hf_r;
  logic [IDX_W-1:0]               fidx_r;
  logic [wstd_pkg::WEIGHT_W-1:0]  fw_r;
  logic                           he_r;
  logic [IDX_W-1:0]               eidx_r;
  logic [wstd_pkg::WEIGHT_W-1:0]  ew_r;
  logic [TIME_BITS-1:0]           ef_r;

  logic                           out_valid_r;
  logic [wstd_pkg::SRV_W-1:0]     out_srv_r;
  logic [TIME_BITS-1:0]           out_start_r;
  logic [TASK_COUNT_BITS-1:0]     out_num_r;
  logic [wstd_pkg::ERR_W-1:0]     out_err_r;

  logic                           ram_we;
  logic [IDX_W-1:0]               ram_waddr;
  logic [ENT_W-1:0]               ram_wdata;
  logic [ENT_W-1:0]               ram_rdata;

  logic [wstd_pkg::WEIGHT_W-1:0]  rd_w;
  logic [TIME_BITS-1:0]           rd_f;
  logic                           rd_en;
  logic                           load_ok;
  logic [TIME_BITS-1:0]           counter_time;
  logic [TIME_BITS-1:0]           clk_sel;
  logic [IDX_W-1:0]               pick;
  logic [wstd_pkg::WEIGHT_W-1:0]  pick_w;
  logic [TIME_BITS:0]             fin_sum;
  logic [TIME_BITS-1:0]           fin;
  logic                           ok;

  assign load_ok      = 32'(in_server_index) < NUM_SERVERS;
  assign counter_time = TIME_BITS'(count_r);
  assign rd_w         = ram_rdata[TIME_BITS +: wstd_pkg::WEIGHT_W];
  assign rd_f         = ram_rdata[TIME_BITS-1:0];
  assign rd_en        = en_r[cmp_idx_r];

  assign clk_sel = hf_r ? clk0_r : ef_r;
  assign pick    = hf_r ? fidx_r : eidx_r;
  assign pick_w  = hf_r ? fw_r : ew_r;
  assign fin_sum = {1'b0, clk_sel} + (TIME_BITS + 1)'(dur_r);
  assign fin     = fin_sum[TIME_BITS] ? '1 : fin_sum[TIME_BITS-1:0];
  assign ok      = (err_r == wstd_pkg::ERR_OK);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = IDX_W'(in_server_index);
    ram_wdata = {in_server_weight, {TIME_BITS{1'b0}}};
    if (cmd.do_load && load_ok) begin
      ram_we = 1'b1;
    end else if (cmd.commit && ok) begin
      ram_we    = 1'b1;
      ram_waddr = pick;
      ram_wdata = {pick_w, fin};
    end
  end

  wstd_ram #(
    .WIDTH (ENT_W),
    .DEPTH (NUM_SERVERS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (scan_idx_r),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r        <= '0;
      clock_r     <= '0;
      count_r     <= '0;
      cmp_v_r     <= 1'b0;
      hf_r        <= 1'b0;
      he_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.do_load && load_ok) begin
        en_r[IDX_W'(in_server_index)] <= 1'b1;
      end
      if (cmd.do_clear) begin
        en_r    <= '0;
        clock_r <= '0;
        count_r <= '0;
      end
      cmp_v_r <= cmd.scan_step;
      if (cmd.do_submit) begin
        hf_r <= 1'b0;
        he_r <= 1'b0;
      end else if (cmp_v_r && rd_en) begin
        if (rd_f <= clk0_r && (!hf_r || rd_w < fw_r)) begin
          hf_r   <= 1'b1;
          fw_r   <= rd_w;
          fidx_r <= cmp_idx_r;
        end
        if (!he_r || rd_f < ef_r) begin
          he_r   <= 1'b1;
          ef_r   <= rd_f;
          ew_r   <= rd_w;
          eidx_r <= cmp_idx_r;
        end else if (rd_f == ef_r && rd_w < ew_r) begin
          ew_r   <= rd_w;
          eidx_r <= cmp_idx_r;
        end
      end
      if (cmd.commit) begin
        out_valid_r <= 1'b1;
        if (ok) begin
          clock_r <= clk_sel;
          count_r <= count_r + 1'b1;
        end
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.do_submit) begin
      clk0_r     <= (counter_time > clock_r) ? counter_time : clock_r;
      dur_r      <= in_task_duration;
      scan_idx_r <= '0;
      if (en_r == '0) begin
        err_r <= wstd_pkg::ERR_NO_SERVER;
      end else if (count_r == '1) begin
        err_r <= wstd_pkg::ERR_FULL;
      end else begin
        err_r <= wstd_pkg::ERR_OK;
      end
    end else if (cmd.scan_step && !sts.scan_last) begin
      scan_idx_r <= scan_idx_r + 1'b1;
    end
    if (cmd.scan_step) begin
      cmp_idx_r <= scan_idx_r;
    end
    if (cmd.commit) begin
      out_srv_r   <= ok ? wstd_pkg::SRV_W'(pick) : '0;
      out_start_r <= ok ? clk_sel : '0;
      out_num_r   <= count_r;
      out_err_r   <= err_r;
    end
  end

  assign sts.any_enabled = (en_r != '0);
  assign sts.count_full  = (count_r == '1);
  assign sts.scan_last   = (scan_idx_r == IDX_W'(NUM_SERVERS - 1));
  assign sts.out_free    = !out_valid_r || out_ready;

  assign out_valid           = out_valid_r;
  assign out_assigned_server = out_srv_r;
  assign out_start_time      = out_start_r;
  assign out_task_number     = out_num_r;
  assign out_error_code      = out_err_r;

endmodule

// ===== rtl/core/weighted_server_task_dispatcher_core.sv =====
// Channel   Direction  Handshake            Payload
// in_       input      in_valid/in_ready    req_type, server_index, server_weight,
//                                           task_duration
// out_      output     out_valid/out_ready  assigned_server, start_time, task_number,
//                                           error_code
//
// Load and clear beats finish in the idle state. An accepted task is latched, then each server
// entry is read from RAM and compared, the last compare is finished and the result is committed.
// A refused submit (no server loaded, counter full) skips the scan and goes straight to commit.
// Reset is synchronous and active low; it disables all servers and clears the clock and task
// counter. Server weights and finish times sit in RAM; a load writes both, a commit the finish time.
// A held result lets new beats in; a finished task waits in its commit cycle until it drains.
module weighted_server_task_dispatcher_core #(
  parameter int NUM_SERVERS     = 16,
  parameter int TASK_COUNT_BITS = 24,
  parameter int TIME_BITS       = 48
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [wstd_pkg::REQ_W-1:0]    in_req_type,
  input  logic [wstd_pkg::SRV_W-1:0]    in_server_index,
  input  logic [wstd_pkg::WEIGHT_W-1:0] in_server_weight,
  input  logic [wstd_pkg::DUR_W-1:0]    in_task_duration,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [wstd_pkg::SRV_W-1:0]    out_assigned_server,
  output logic [TIME_BITS-1:0]          out_start_time,
  output logic [TASK_COUNT_BITS-1:0]    out_task_number,
  output logic [wstd_pkg::ERR_W-1:0]    out_error_code
);

  // The controller sequences an accepted task through idle, scan, final compare and
  // commit; the datapath holds all server state and the compare registers.
  wstd_pkg::cmd_t cmd;
  wstd_pkg::sts_t sts;

  wstd_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_req_type (in_req_type),
    .in_ready    (in_ready),
    .sts         (sts),
    .cmd         (cmd)
  );

  // During the scan, each enabled server's entry is compared against two running
  // bests: the lightest server already free at the arrival clock, and the
  // lightest among those with the earliest finish time. When no server is
  // free, the second one is the pick and the clock jumps to its finish time.
  wstd_dp #(
    .NUM_SERVERS     (NUM_SERVERS),
    .TASK_COUNT_BITS (TASK_COUNT_BITS),
    .TIME_BITS       (TIME_BITS)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .in_server_index     (in_server_index),
    .in_server_weight    (in_server_weight),
    .in_task_duration    (in_task_duration),
    .out_ready           (out_ready),
    .out_valid           (out_valid),
    .out_assigned_server (out_assigned_server),
    .out_start_time      (out_start_time),
    .out_task_number     (out_task_number),
    .out_error_code      (out_error_code)
  );

endmodule
